>>> design/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

    // Fixed-point constants
    localparam int unsigned Q12_ONE        = 4096;
    localparam int unsigned PI_OVER_3_Q14  = 17157;
    localparam int unsigned HUE_SHIFT      = 13;
    localparam int unsigned SAT_Q_WIDTH    = 16;
    localparam int unsigned DIV_CELLS      = SAT_Q_WIDTH - 1;
    // Divider lanes give x*2^15/d; the hue lane needs x*2^12/d
    localparam int unsigned HUE_Q_DROP     = 3;
    localparam int unsigned HUE_MAG_WIDTH  = SAT_Q_WIDTH - HUE_Q_DROP;
    localparam int unsigned POS_WIDTH      = 15;
    localparam int unsigned PROD_WIDTH     = 30;

    localparam logic [POS_WIDTH-1:0] POS_GREEN_BASE = POS_WIDTH'(2 * Q12_ONE);
    localparam logic [POS_WIDTH-1:0] POS_BLUE_BASE  = POS_WIDTH'(4 * Q12_ONE);
    localparam logic [POS_WIDTH-1:0] POS_WRAP       = POS_WIDTH'(6 * Q12_ONE);

    // Dominant component
    typedef enum logic [1:0] {
        SEXT_RED,
        SEXT_GREEN,
        SEXT_BLUE
    } t_sextant;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [15:0] hue_angle;
        logic [15:0] saturation_level;
        logic [7:0]  value_level;
    } t_hsv_out;

    // Data carried along the divider chain: two restoring lanes plus pixel info
    typedef struct packed {
        logic [7:0]             value;
        logic [7:0]             delta;
        logic [7:0]             hue_rem;
        logic [SAT_Q_WIDTH-1:0] hue_q;
        logic [7:0]             sat_rem;
        logic [SAT_Q_WIDTH-1:0] sat_q;
        logic                   hue_neg;
        t_sextant               sextant;
        logic                   grey;
    } t_cell_data;

endpackage

>>> design/rhc_front.sv
// Front stage: max, min, delta, dominant component and first quotient bit.
module rhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rhc_pkg::t_pixel_in  i_pixel,
    output logic                o_valid,
    input  logic                i_ready,
    output rhc_pkg::t_cell_data o_data
);
    import rhc_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [8:0] diff;
    logic [7:0] mag;
    logic       hue_bit;
    logic       sat_bit;

    assign o_ready = !r_valid || i_ready;

    // Find extremes and the pair difference of the dominant component
    always_comb begin
        mx = i_pixel.red;
        mn = i_pixel.red;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.blue  > mx) mx = i_pixel.blue;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.blue  < mn) mn = i_pixel.blue;

        n_data       = '0;
        n_data.value = mx;
        n_data.delta = mx - mn;
        n_data.grey  = (mx == mn);

        if (mx == i_pixel.red) begin
            n_data.sextant = SEXT_RED;
            diff = {1'b0, i_pixel.green} - {1'b0, i_pixel.blue};
        end else if (mx == i_pixel.green) begin
            n_data.sextant = SEXT_GREEN;
            diff = {1'b0, i_pixel.blue} - {1'b0, i_pixel.red};
        end else begin
            n_data.sextant = SEXT_BLUE;
            diff = {1'b0, i_pixel.red} - {1'b0, i_pixel.green};
        end
        n_data.hue_neg = diff[8];
        mag = diff[8] ? 8'(-diff) : diff[7:0];

        // Leading quotient bit: numerator never exceeds divisor
        hue_bit        = (mag >= n_data.delta);
        n_data.hue_rem = hue_bit ? 8'(mag - n_data.delta) : mag;
        n_data.hue_q   = {{(SAT_Q_WIDTH-1){1'b0}}, hue_bit};
        sat_bit        = (n_data.delta >= mx);
        n_data.sat_rem = sat_bit ? 8'(n_data.delta - mx) : n_data.delta;
        n_data.sat_q   = {{(SAT_Q_WIDTH-1){1'b0}}, sat_bit};
    end

    // Hold or advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/rhc_div_cell.sv
// Divider cell: one restoring step on both the hue and saturation lanes.
module rhc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rhc_pkg::t_cell_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rhc_pkg::t_cell_data o_data
);
    import rhc_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic [8:0] hue_trial;
    logic [8:0] sat_trial;
    logic       hue_bit;
    logic       sat_bit;

    assign o_ready = !r_valid || i_ready;

    // Double the remainder, subtract the divisor where it fits
    always_comb begin
        n_data    = i_data;
        hue_trial = {i_data.hue_rem, 1'b0};
        hue_bit   = (hue_trial >= {1'b0, i_data.delta});
        n_data.hue_rem = hue_bit ? 8'(hue_trial - {1'b0, i_data.delta}) : hue_trial[7:0];
        n_data.hue_q   = {i_data.hue_q[SAT_Q_WIDTH-2:0], hue_bit};

        sat_trial = {i_data.sat_rem, 1'b0};
        sat_bit   = (sat_trial >= {1'b0, i_data.value});
        n_data.sat_rem = sat_bit ? 8'(sat_trial - {1'b0, i_data.value}) : sat_trial[7:0];
        n_data.sat_q   = {i_data.sat_q[SAT_Q_WIDTH-2:0], sat_bit};
    end

    // Hold or advance the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/rhc_back.sv
// Back end: sextant position, scaling to radians and the output register.
module rhc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rhc_pkg::t_cell_data i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rhc_pkg::t_hsv_out   o_hsv
);
    import rhc_pkg::*;

    logic                     r_pos_valid;
    logic [POS_WIDTH-1:0]     r_pos;
    logic [15:0]              r_sat;
    logic [7:0]               r_value;
    logic                     r_out_valid;
    t_hsv_out                 r_hsv;
    logic [POS_WIDTH-1:0]     n_pos;
    logic [POS_WIDTH-1:0]     base;
    logic [HUE_MAG_WIDTH-1:0] mag;
    logic [PROD_WIDTH-1:0]    prod;
    logic                     pos_ready;
    logic                     out_ready;

    assign out_ready = !r_out_valid || i_ready;
    assign pos_ready = !r_pos_valid || out_ready;
    assign o_ready   = pos_ready;

    // Place the truncated quotient in its sextant, wrapping negatives
    always_comb begin
        mag = i_data.hue_q[SAT_Q_WIDTH-1:HUE_Q_DROP];
        case (i_data.sextant)
            SEXT_GREEN: base = POS_GREEN_BASE;
            SEXT_BLUE:  base = POS_BLUE_BASE;
            default:    base = (i_data.hue_neg && mag != '0) ? POS_WRAP : '0;
        endcase
        if (i_data.grey) begin
            n_pos = '0;
        end else if (i_data.hue_neg) begin
            n_pos = base - POS_WIDTH'(mag);
        end else begin
            n_pos = base + POS_WIDTH'(mag);
        end
    end

    // Scale position by pi/3
    assign prod = PROD_WIDTH'(r_pos) * PROD_WIDTH'(PI_OVER_3_Q14);

    // Hold or advance position and output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pos_ready) begin
                r_pos_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_pos_valid;
            end
        end
        if (pos_ready && i_valid) begin
            r_pos   <= n_pos;
            r_sat   <= i_data.grey ? 16'd0 : i_data.sat_q;
            r_value <= i_data.value;
        end
        if (out_ready && r_pos_valid) begin
            r_hsv.hue_angle        <= prod[HUE_SHIFT+15:HUE_SHIFT];
            r_hsv.saturation_level <= r_sat;
            r_hsv.value_level      <= r_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hsv   = r_hsv;

endmodule

>>> design/rgb_to_hsv_converter_unit.sv
// Top level of the RGB to HSV converter: front stage, divider chain, back end.
//
//  Channel | Direction | Handshake                   | Payload
//  pixel   | in        | i_in_valid / o_in_ready     | i_pixel (red, green, blue)
//  hsv     | out       | o_out_valid / i_out_ready   | o_hsv (hue, saturation, value)
//
// The pipeline has one front stage, fifteen divider cells and two back stages.
// One pixel is taken every cycle while the result side keeps taking transfers.
// Each stage holds its own valid bit and advances when the next one is empty or
// moving, so empty slots close up while the output stalls.
// Synchronous reset clears every valid bit; data registers are not reset.
module rgb_to_hsv_converter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rhc_pkg::t_pixel_in i_pixel,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rhc_pkg::t_hsv_out  o_hsv
);
    import rhc_pkg::*;

    t_cell_data stage_data  [DIV_CELLS+1];
    logic       stage_valid [DIV_CELLS+1];
    logic       stage_ready [DIV_CELLS+1];

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_pixel (i_pixel),
        .o_valid (stage_valid[0]),
        .i_ready (stage_ready[0]),
        .o_data  (stage_data[0])
    );

    // Chain of restoring division cells
    for (genvar k = 1; k <= DIV_CELLS; k++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[k-1]),
            .o_ready (stage_ready[k-1]),
            .i_data  (stage_data[k-1]),
            .o_valid (stage_valid[k]),
            .i_ready (stage_ready[k]),
            .o_data  (stage_data[k])
        );
    end

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid[DIV_CELLS]),
        .o_ready (stage_ready[DIV_CELLS]),
        .i_data  (stage_data[DIV_CELLS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_hsv   (o_hsv)
    );

endmodule

>>> design/rhc_checker.sv
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rhc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rhc_pkg::t_hsv_out  o_hsv
);
    import rhc_pkg::*;

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hsv))
        else $error("result changed while stalled");

    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

    // Saturation never exceeds one
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hsv.saturation_level <= 16'd32768)
        else $error("saturation out of range");

    // A grey pixel has no saturation and no hue
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hsv.saturation_level == 16'd0 |-> o_hsv.hue_angle == 16'd0)
        else $error("hue set on grey pixel");

    // Hue stays below two pi
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_hsv.hue_angle <= 16'd51471)
        else $error("hue out of range");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_hsv       (o_hsv)
);
